/* hdl/gbmc_pkg.sv */
// Package with request, response and command types and register map constants.
`timescale 1ns / 1ps

package gbmc_pkg;

	localparam logic [1:0] OP_READ   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_DBLANK = 2'd2;
	localparam logic [1:0] OP_VBLANK = 2'd3;

	localparam logic [13:0] OFF_CTRL0    = 14'h0000;
	localparam logic [13:0] OFF_CTRL1    = 14'h0010;
	localparam logic [13:0] OFF_CTRL2    = 14'h0020;
	localparam logic [13:0] OFF_SLOT_ID  = 14'h0030;
	localparam logic [13:0] OFF_DMA_CTRL = 14'h1000;
	localparam logic [13:0] OFF_VRAM_TIM = 14'h2000;
	localparam logic [13:0] OFF_DRAM_SZ  = 14'h3000;
	localparam logic [13:0] DMA_ADDR_MASK = 14'h3F0F;
	localparam logic [3:0]  DMA_LINE_NIB  = 4'hD;
	localparam logic [3:0]  DMA_LINE_IDX  = 4'd10;
	localparam int          DMA_ENTRIES   = 14;

	localparam logic [31:0] C0_RESET     = 32'h0000_0001;
	localparam logic [31:0] C0_CS8       = 32'h0000_0002;
	localparam logic [31:0] C0_CPU_IMASK = 32'h0000_0004;
	localparam logic [31:0] C0_CPU_INT   = 32'h0000_0008;
	localparam logic [31:0] C0_BE_IMASK  = 32'h0000_0010;
	localparam logic [31:0] C0_BE_INT    = 32'h0000_0020;
	localparam logic [31:0] C0_VBL_IMASK = 32'h0000_0040;
	localparam logic [31:0] C0_VBL_INT   = 32'h0000_0080;
	localparam logic [31:0] C0_VBLANK    = 32'h0000_0100;
	localparam logic [31:0] C0_VIO_IMASK = 32'h0000_0200;
	localparam logic [31:0] C0_VIO_INT   = 32'h0000_0400;
	localparam logic [31:0] C0_VIOBLANK  = 32'h0000_0800;

	typedef struct packed {
		logic [1:0]  operation;
		logic [13:0] register_offset;
		logic [31:0] write_data;
		logic        blank_level;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        reset_request;
		logic        interrupt_request;
		logic        host_interrupt_level;
		logic        unknown_register;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;

	typedef enum logic [3:0] {
		SEL_NONE,
		SEL_CTRL0,
		SEL_CTRL1,
		SEL_CTRL2,
		SEL_SLOT_ID,
		SEL_DMA_CTRL,
		SEL_DMA_ADDR,
		SEL_VRAM_TIM,
		SEL_DRAM_SZ
	} sel_t;

endpackage

/* hdl/gbmc_ctrl.sv */
// Controller state machine that sequences requests through the register datapath.
`timescale 1ns / 1ps

module gbmc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output gbmc_pkg::cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && req_valid;
		cmd.commit = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready);
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hdl/gbmc_dp.sv */
// Datapath holding the register file, the address decode and the response register.
`timescale 1ns / 1ps

module gbmc_dp #(
	parameter int BOARD_STEP = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gbmc_pkg::cmd_t  cmd,
	input  gbmc_pkg::req_t  req,
	input  logic            cfg_wr,
	input  logic [3:0]      cfg_data,
	output gbmc_pkg::rsp_t  rsp
);

	localparam logic [3:0] STEP = 4'(BOARD_STEP);

	gbmc_pkg::req_t req_q;
	gbmc_pkg::rsp_t rsp_q;
	logic [31:0] ctrl0_q;
	logic [31:0] ctrl1_q;
	logic [31:0] ctrl2_q;
	logic [31:0] slot_id_q;
	logic [31:0] dma_ctrl_q;
	logic [31:0] dma_addr_q [gbmc_pkg::DMA_ENTRIES];
	logic [31:0] vram_tim_q;
	logic [31:0] dram_sz_q;

	gbmc_pkg::sel_t sel;
	logic [3:0]     nib;
	logic [3:0]     dma_idx;
	logic [31:0]    rd;
	logic [31:0]    ctrl0_next;
	logic [31:0]    ctrl1_next;
	logic [31:0]    wdata;
	logic           rst;
	logic           irq;
	logic           unk;
	logic           is_write;

	always_comb begin
		nib     = req_q.register_offset[7:4];
		sel     = gbmc_pkg::SEL_NONE;
		dma_idx = nib - 4'd1;
		case (req_q.register_offset)
			gbmc_pkg::OFF_CTRL0:    sel = gbmc_pkg::SEL_CTRL0;
			gbmc_pkg::OFF_CTRL1:    sel = gbmc_pkg::SEL_CTRL1;
			gbmc_pkg::OFF_CTRL2:    sel = gbmc_pkg::SEL_CTRL2;
			gbmc_pkg::OFF_SLOT_ID:  sel = gbmc_pkg::SEL_SLOT_ID;
			gbmc_pkg::OFF_DMA_CTRL: sel = gbmc_pkg::SEL_DMA_CTRL;
			gbmc_pkg::OFF_VRAM_TIM: sel = gbmc_pkg::SEL_VRAM_TIM;
			gbmc_pkg::OFF_DRAM_SZ:  sel = gbmc_pkg::SEL_DRAM_SZ;
			default: begin
				if ((req_q.register_offset & gbmc_pkg::DMA_ADDR_MASK)
						== gbmc_pkg::OFF_DMA_CTRL && nib != 4'd0) begin
					sel = gbmc_pkg::SEL_DMA_ADDR;
				end
			end
		endcase
		if (nib == gbmc_pkg::DMA_LINE_NIB) begin
			dma_idx = gbmc_pkg::DMA_LINE_IDX;
		end else if (nib > gbmc_pkg::DMA_LINE_NIB) begin
			dma_idx = nib - 4'd2;
		end
	end

	always_comb begin
		case (sel)
			gbmc_pkg::SEL_CTRL0:    rd = ctrl0_q;
			gbmc_pkg::SEL_CTRL1:    rd = ctrl1_q;
			gbmc_pkg::SEL_CTRL2:    rd = ctrl2_q;
			gbmc_pkg::SEL_SLOT_ID:  rd = slot_id_q;
			gbmc_pkg::SEL_DMA_CTRL: rd = dma_ctrl_q;
			gbmc_pkg::SEL_DMA_ADDR: rd = dma_addr_q[dma_idx];
			gbmc_pkg::SEL_VRAM_TIM: rd = vram_tim_q;
			gbmc_pkg::SEL_DRAM_SZ:  rd = dram_sz_q;
			default:                rd = 32'd0;
		endcase
	end

	always_comb begin
		wdata      = req_q.write_data;
		ctrl0_next = ctrl0_q;
		ctrl1_next = ctrl1_q;
		rst        = 1'b0;
		irq        = 1'b0;
		unk        = 1'b0;
		is_write   = 1'b0;
		case (req_q.operation)
			gbmc_pkg::OP_READ: begin
				unk = (sel == gbmc_pkg::SEL_NONE);
			end
			gbmc_pkg::OP_WRITE: begin
				unk      = (sel == gbmc_pkg::SEL_NONE);
				is_write = 1'b1;
				if (sel == gbmc_pkg::SEL_CTRL0) begin
					rst = |(wdata & gbmc_pkg::C0_RESET);
					irq = (|(wdata & gbmc_pkg::C0_CPU_INT) && |(wdata & gbmc_pkg::C0_CPU_IMASK))
						|| (|(wdata & gbmc_pkg::C0_BE_INT) && |(wdata & gbmc_pkg::C0_BE_IMASK));
					ctrl0_next = wdata & ~gbmc_pkg::C0_RESET;
				end
				if (sel == gbmc_pkg::SEL_CTRL1) begin
					ctrl1_next = wdata;
				end
			end
			gbmc_pkg::OP_DBLANK: begin
				if (req_q.blank_level) begin
					ctrl0_next = ctrl0_q | gbmc_pkg::C0_VBL_INT | gbmc_pkg::C0_VBLANK;
					irq        = |(ctrl0_q & gbmc_pkg::C0_VBL_IMASK);
				end else begin
					ctrl0_next = ctrl0_q & ~gbmc_pkg::C0_VBLANK;
				end
			end
			default: begin
				if (req_q.blank_level) begin
					ctrl0_next = ctrl0_q | gbmc_pkg::C0_VIO_INT | gbmc_pkg::C0_VIOBLANK;
					irq        = |(ctrl0_q & gbmc_pkg::C0_VIO_IMASK);
				end else begin
					ctrl0_next = ctrl0_q & ~gbmc_pkg::C0_VIOBLANK;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.commit) begin
			rsp_q.read_data            <= (req_q.operation == gbmc_pkg::OP_READ) ? rd : 32'd0;
			rsp_q.reset_request        <= rst;
			rsp_q.interrupt_request    <= irq;
			rsp_q.host_interrupt_level <= ctrl1_next[0];
			rsp_q.unknown_register     <= unk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl0_q    <= gbmc_pkg::C0_CS8;
			ctrl1_q    <= 32'd0;
			ctrl2_q    <= 32'd0;
			slot_id_q  <= {24'd0, STEP, 4'd0};
			dma_ctrl_q <= 32'd0;
			for (int i = 0; i < gbmc_pkg::DMA_ENTRIES; i++) begin
				dma_addr_q[i] <= 32'd0;
			end
			vram_tim_q <= 32'd0;
			dram_sz_q  <= 32'd0;
		end else begin
			if (cmd.commit) begin
				ctrl0_q <= ctrl0_next;
				ctrl1_q <= ctrl1_next;
				if (is_write) begin
					case (sel)
						gbmc_pkg::SEL_CTRL2:    ctrl2_q <= wdata;
						gbmc_pkg::SEL_SLOT_ID:  slot_id_q <= wdata;
						gbmc_pkg::SEL_DMA_CTRL: dma_ctrl_q <= wdata;
						gbmc_pkg::SEL_DMA_ADDR: dma_addr_q[dma_idx] <= wdata;
						gbmc_pkg::SEL_VRAM_TIM: vram_tim_q <= wdata;
						gbmc_pkg::SEL_DRAM_SZ:  dram_sz_q <= wdata;
						default: ;
					endcase
				end
			end
			if (cfg_wr) begin
				slot_id_q <= {24'd0, STEP, cfg_data};
			end
		end
	end

	assign rsp = rsp_q;

endmodule

/* hdl/graphics_board_memory_controller_regs_core.sv */
// Top level of the memory controller register block.
// A request is held in the request register while the controller executes it; the
// response register loads on commit, which waits until any held response is taken.
// The controller holds one request at a time and the response register frees the
// input once it is loaded. Reset: arst_n clears the controller and loads every
// register-file register with its reset value at once; no sweep follows.
`timescale 1ns / 1ps

module graphics_board_memory_controller_regs_core #(
	parameter int BOARD_STEP = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  gbmc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output gbmc_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [3:0]     cfg_data
);

	gbmc_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	gbmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	gbmc_dp #(
		.BOARD_STEP (BOARD_STEP)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.cfg_wr   (cfg_valid),
		.cfg_data (cfg_data),
		.rsp      (rsp)
	);

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("A second request was accepted while one was in flight.");

	a_unknown_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.unknown_register) |-> (rsp.read_data == 32'd0))
		else $error("An unknown register returned nonzero data.");

	a_reset_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.reset_request) |-> (rsp.read_data == 32'd0 && !rsp.unknown_register))
		else $error("A reset request came from something other than a write.");

	a_rsp_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && !rsp_valid) |=> ##1 rsp_valid)
		else $error("A response did not follow an accepted request.");
`endif

endmodule
